// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// File: hdl/cqmd_pkg.sv
// ----------------------------------------------------------------------------
// cqmd_pkg
// Types and constants shared by the byte queue controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cqmd_pkg;

    // Queue geometry
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int FILL_W = 5;

    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_DROP   = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] item_char;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic [7:0]          char_out;
        logic                last;
        logic [FILL_W-1:0]   fill_count;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_LIST_RD,
        S_LIST_OUT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    capture;
        logic    enq_write;
        logic    src_clear;
        logic    src_inc;
        logic    shift_init;
        logic    rd_src;
        logic    shift_write;
        logic    count_from_dst;
        logic    out_load;
        status_t out_status;
        logic    out_use_data;
        logic    out_last;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic count_zero;
        logic full;
        logic match;
        logic src_last;
        logic src_end;
        logic out_free;
    } dp_stat_t;

endpackage

// File: hdl/cqmd_datapath.sv
// ----------------------------------------------------------------------------
// cqmd_datapath
// Entry memory, count, search/shift pointers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cqmd_datapath
    import cqmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rdata_reg;
    in_item_t         item_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] src_reg, src_next;
    logic [CNT_W-1:0] dst_reg, dst_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg;
    logic [CNT_W-1:0] src_plus;

    assign src_plus = CNT_W'(src_reg + 1'b1);

    // Hold the accepted beat for the whole operation
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.enq_write)
        begin
            mem[count_reg[IDX_W-1:0]] <= item_reg.item_char;
        end
        else if (cmd.shift_write)
        begin
            mem[dst_reg[IDX_W-1:0]] <= rdata_reg;
        end
        if (cmd.rd_src)
        begin
            rdata_reg <= mem[src_reg[IDX_W-1:0]];
        end
    end

    // Advance count and pointers
    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq_write)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (cmd.count_from_dst)
        begin
            // after the move, dst points one past the last kept entry
            count_next = dst_reg;
        end

        src_next = src_reg;
        dst_next = dst_reg;
        if (cmd.src_clear)
        begin
            src_next = '0;
        end
        else if (cmd.shift_init)
        begin
            if (item_reg.op == OP_REMOVE)
            begin
                dst_next = src_reg;
                src_next = src_plus;
            end
            else
            begin
                dst_next = '0;
            end
        end
        else if (cmd.shift_write)
        begin
            src_next = src_plus;
            dst_next = CNT_W'(dst_reg + 1'b1);
        end
        else if (cmd.src_inc)
        begin
            src_next = src_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        dst_reg <= dst_next;
    end

    // Result register: load when free, drop valid once the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.status     <= cmd.out_status;
            out_reg.char_out   <= cmd.out_use_data ? rdata_reg : 8'd0;
            out_reg.last       <= cmd.out_last;
            out_reg.fill_count <= FILL_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Status toward the controller
    assign stat.op         = item_reg.op;
    assign stat.count_zero = (count_reg == '0);
    assign stat.full       = (count_reg >= CNT_W'(DEPTH));
    assign stat.match      = (rdata_reg == item_reg.item_char);
    assign stat.src_last   = (src_plus == count_reg);
    assign stat.src_end    = (src_reg >= count_reg);
    assign stat.out_free   = !out_valid_reg;

endmodule

// File: hdl/cqmd_ctrl.sv
// ----------------------------------------------------------------------------
// cqmd_ctrl
// Sequencer for enqueue, list, search and gap-closing moves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cqmd_ctrl
    import cqmd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    if (stat.op == OP_ENQ || stat.count_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (stat.op == OP_LIST)
                    begin
                        state_next = S_LIST_RD;
                    end
                    else
                    begin
                        state_next = S_SRCH_RD;
                    end
                end
            end
            S_LIST_RD:
            begin
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.src_last ? S_IDLE : S_LIST_RD;
                end
            end
            S_SRCH_RD:
            begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (stat.match)
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (!stat.src_last)
                begin
                    state_next = S_SRCH_RD;
                end
                else if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SHIFT_RD:
            begin
                state_next = stat.src_end ? S_FINISH : S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                state_next = S_SHIFT_RD;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd          = '0;
        cmd.out_status = ST_OK;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    if (stat.op == OP_ENQ)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.enq_write  = !stat.full;
                        cmd.out_status = stat.full ? ST_FULL : ST_OK;
                    end
                    else if (stat.count_zero)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.src_clear = 1'b1;
                    end
                end
            end
            S_LIST_RD, S_SRCH_RD:
            begin
                cmd.rd_src = 1'b1;
            end
            S_LIST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_use_data = 1'b1;
                    cmd.out_last     = stat.src_last;
                    cmd.src_inc      = !stat.src_last;
                end
            end
            S_SRCH_CMP:
            begin
                if (stat.match)
                begin
                    cmd.shift_init = 1'b1;
                end
                else if (!stat.src_last)
                begin
                    cmd.src_inc = 1'b1;
                end
                else if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_status = ST_NOTFOUND;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.rd_src = !stat.src_end;
            end
            S_SHIFT_WR:
            begin
                cmd.shift_write = 1'b1;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.count_from_dst = 1'b1;
                    cmd.out_load       = 1'b1;
                    cmd.out_last       = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/char_queue_with_match_delete.sv
// Byte queue with delete-by-value. One beat on in_item carries an operation:
// enqueue, remove first match, drop entries before first match, or list.
// Each operation yields one out_item beat, except list, which yields one
// beat per stored byte, oldest first, with last set on the final beat.
// in_ready is high only while no operation is in progress; one operation
// runs at a time. Enqueue and operations on an empty queue load their result
// from S_EXEC once the output register is free, and the next input beat is
// taken in S_IDLE after that. List alternates S_LIST_RD and S_LIST_OUT, one
// beat loaded per stored byte. Remove and drop read and compare each entry
// searched, then read and write each entry moved; the entry memory, read
// through one registered port once per step, sets this pacing.
// Results sit in an output register; while the receiver stalls, the held
// beat stays put and the next result waits, but a new input beat is still
// taken once the operation's last result has been loaded.
// Reset empties the queue; memory contents are not cleared.
// ----------------------------------------------------------------------------
// char_queue_with_match_delete
// Top level: controller and datapath of the bounded byte queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module char_queue_with_match_delete
    import cqmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    cqmd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cqmd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Checks
    `ASSERT_CLK(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")
    `ASSERT_NEVER(a_char_zero, out_valid && out_item.status != ST_OK && out_item.char_out != 8'd0, "stray char")
    `ASSERT_CLK(a_full_count, (out_valid && out_item.status == ST_FULL) |-> (out_item.fill_count == FILL_W'(DEPTH)), "full with room")
    `ASSERT_CLK(a_empty_beat, (out_valid && out_item.status == ST_EMPTY) |-> (out_item.fill_count == '0 && out_item.last), "bad empty beat")

endmodule
